// ----- rtl/asp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package asp_pkg;

   localparam int unsigned NUM_ALERTS = 10;
   localparam int unsigned SHOWN_W    = 4;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned LEVEL_W    = 14;
   localparam int unsigned TEMP_W     = 12;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // priority positions with sensor-driven behaviour
   localparam int unsigned POS_TEMP_CRIT = 1;
   localparam int unsigned POS_TEMP_HIGH = 2;
   localparam int unsigned POS_BATT_CRIT = 4;
   localparam int unsigned POS_BATT_LOW  = 5;

   localparam logic [SHOWN_W-1:0] SHOWN_NONE    = 4'd10;
   localparam logic [TIME_W-1:0]  NEVER_TIMEOUT = 32'hFFFF_FFFF;

   localparam logic [LEVEL_W-1:0]       BATT_LOW_RESET   = 14'd3000;
   localparam logic [LEVEL_W-1:0]       BATT_CRIT_RESET  = 14'd1000;
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RESET  = 12'sd960;
   localparam logic signed [TEMP_W-1:0] TEMP_REL_RESET   = 12'sd720;
   localparam logic signed [TEMP_W-1:0] TEMP_CRIT_RESET  = 12'sd1120;
   localparam logic [TIME_W-1:0]        BATT_DELAY_RESET = 32'd2000;
   localparam logic [TIME_W-1:0]        TEMP_DELAY_RESET = 32'd0;

   typedef logic [NUM_ALERTS-1:0] alert_mask_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BATT_LOW   = 3'd0,
      CSR_BATT_CRIT  = 3'd1,
      CSR_TEMP_HIGH  = 3'd2,
      CSR_TEMP_REL   = 3'd3,
      CSR_TEMP_CRIT  = 3'd4,
      CSR_BATT_DELAY = 3'd5,
      CSR_TEMP_DELAY = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic advance;
      logic ext_clear;
      logic ext_raise;
      logic up;
      logic down;
   } slot_ctrl_type;

   typedef struct packed {
      logic raised;
      logic first_raise;
      logic timeout_hit;
   } slot_status_type;

endpackage

`default_nettype wire

// ----- rtl/asp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface asp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic [13:0] battery_level;
   logic signed [11:0] cpu_temp;
   logic        charging;
   logic [9:0]  raise_mask;
   logic [9:0]  clear_mask;
   logic        ignore_alerts;

   modport source (
      output valid, now_ms, battery_level, cpu_temp, charging, raise_mask, clear_mask,
             ignore_alerts,
      input  ready
   );
   modport sink (
      input  valid, now_ms, battery_level, cpu_temp, charging, raise_mask, clear_mask,
             ignore_alerts,
      output ready
   );
endinterface

interface asp_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] raised_mask;
   logic [3:0] shown_alert;
   logic       shutdown_request;
   logic       low_battery_action;
   logic       overheat_action;

   modport source (
      output valid, raised_mask, shown_alert, shutdown_request, low_battery_action,
             overheat_action,
      input  ready
   );
   modport sink (
      input  valid, raised_mask, shown_alert, shutdown_request, low_battery_action,
             overheat_action,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/alert_supervisor_priority_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// an accepted transaction passes through the input register, then the result register
// one transaction per cycle unless the output stalls; while a finished result waits
// in the output register the input register takes one more, then holds ready low
// reset (synchronous): clears alert flags, handled marks, raise times,
// the shutdown latch and valid bits, and loads the threshold register defaults

module alert_supervisor_priority_top
   import asp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   asp_req_if.sink                     req_ch,
   asp_rsp_if.source                   rsp_ch,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // threshold registers
   logic [LEVEL_W-1:0]       batt_low_ff;
   logic [LEVEL_W-1:0]       batt_crit_ff;
   logic signed [TEMP_W-1:0] temp_high_ff;
   logic signed [TEMP_W-1:0] temp_rel_ff;
   logic signed [TEMP_W-1:0] temp_crit_ff;
   logic [TIME_W-1:0]        batt_delay_ff;
   logic [TIME_W-1:0]        temp_delay_ff;

   // input register
   logic                     s1_valid_ff;
   logic [TIME_W-1:0]        s1_now_ff;
   logic [LEVEL_W-1:0]       s1_level_ff;
   logic signed [TEMP_W-1:0] s1_temp_ff;
   logic                     s1_charging_ff;
   alert_mask_type           s1_raise_ff;
   alert_mask_type           s1_clear_ff;
   logic                     s1_ignore_ff;

   // result register
   logic                     rsp_valid_ff;
   alert_mask_type           rsp_raised_ff;
   logic [SHOWN_W-1:0]       rsp_shown_ff;
   logic                     rsp_shutdown_ff;
   logic                     rsp_low_act_ff;
   logic                     rsp_heat_act_ff;

   logic                     shutdown_ff, shutdown_in;
   logic                     advance;
   slot_ctrl_type            slot_ctrl   [NUM_ALERTS];
   logic [TIME_W-1:0]        slot_timeout[NUM_ALERTS];
   slot_status_type          slot_status [NUM_ALERTS];
   alert_mask_type           raised_next;
   alert_mask_type           hit_vec;
   logic [SHOWN_W-1:0]       shown_next;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         batt_low_ff   <= BATT_LOW_RESET;
         batt_crit_ff  <= BATT_CRIT_RESET;
         temp_high_ff  <= TEMP_HIGH_RESET;
         temp_rel_ff   <= TEMP_REL_RESET;
         temp_crit_ff  <= TEMP_CRIT_RESET;
         batt_delay_ff <= BATT_DELAY_RESET;
         temp_delay_ff <= TEMP_DELAY_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BATT_LOW:   batt_low_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_BATT_CRIT:  batt_crit_ff  <= csr_wdata[LEVEL_W-1:0];
            CSR_TEMP_HIGH:  temp_high_ff  <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_TEMP_REL:   temp_rel_ff   <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_TEMP_CRIT:  temp_crit_ff  <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_BATT_DELAY: batt_delay_ff <= csr_wdata[TIME_W-1:0];
            CSR_TEMP_DELAY: temp_delay_ff <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_now_ff      <= req_ch.now_ms;
         s1_level_ff    <= req_ch.battery_level;
         s1_temp_ff     <= req_ch.cpu_temp;
         s1_charging_ff <= req_ch.charging;
         s1_raise_ff    <= req_ch.raise_mask;
         s1_clear_ff    <= req_ch.clear_mask;
         s1_ignore_ff   <= req_ch.ignore_alerts;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_ALERTS; i++) begin
         slot_ctrl[i].advance   = advance;
         slot_ctrl[i].ext_clear = s1_clear_ff[i];
         slot_ctrl[i].ext_raise = s1_raise_ff[i];
         slot_ctrl[i].up        = 1'b0;
         slot_ctrl[i].down      = 1'b0;
         slot_timeout[i]        = NEVER_TIMEOUT;
      end
      slot_ctrl[POS_TEMP_CRIT].up   = s1_temp_ff >= temp_crit_ff;
      slot_timeout[POS_TEMP_CRIT]   = temp_delay_ff;
      slot_ctrl[POS_TEMP_HIGH].up   = s1_temp_ff >= temp_high_ff;
      slot_ctrl[POS_TEMP_HIGH].down = s1_temp_ff <= temp_rel_ff;
      slot_ctrl[POS_BATT_CRIT].up   = !s1_charging_ff && (s1_level_ff < batt_crit_ff);
      slot_ctrl[POS_BATT_CRIT].down = s1_charging_ff;
      slot_timeout[POS_BATT_CRIT]   = batt_delay_ff;
      slot_ctrl[POS_BATT_LOW].up    = !s1_charging_ff && (s1_level_ff < batt_low_ff);
      slot_ctrl[POS_BATT_LOW].down  = s1_charging_ff;
   end

   for (genvar g = 0; g < NUM_ALERTS; g++) begin : g_slot
      asp_slot u_slot (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (slot_ctrl[g]),
         .now_ms  (s1_now_ff),
         .timeout (slot_timeout[g]),
         .status  (slot_status[g])
      );
      assign raised_next[g] = slot_status[g].raised;
      assign hit_vec[g]     = slot_status[g].timeout_hit;
   end

   asp_prio u_prio (
      .raised_mask   (raised_next),
      .ignore_alerts (s1_ignore_ff),
      .shown_alert   (shown_next)
   );

   assign shutdown_in = shutdown_ff || (|hit_vec);

   always_ff @(posedge clock) begin
      if (reset) begin
         shutdown_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            shutdown_ff <= shutdown_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_raised_ff   <= raised_next;
         rsp_shown_ff    <= shown_next;
         rsp_shutdown_ff <= shutdown_in;
         rsp_low_act_ff  <= slot_status[POS_BATT_LOW].first_raise;
         rsp_heat_act_ff <= slot_status[POS_TEMP_HIGH].first_raise;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.raised_mask        = rsp_raised_ff;
   assign rsp_ch.shown_alert        = rsp_shown_ff;
   assign rsp_ch.shutdown_request   = rsp_shutdown_ff;
   assign rsp_ch.low_battery_action = rsp_low_act_ff;
   assign rsp_ch.overheat_action    = rsp_heat_act_ff;

   // shutdown latch is sticky
   a_shutdown_sticky: assert property (@(posedge clock) disable iff (reset)
      shutdown_ff |=> shutdown_ff)
      else $error("shutdown latch dropped");

   // an action pulse only comes with its alert raised
   a_action_raised: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_low_act_ff |-> rsp_raised_ff[POS_BATT_LOW])
      else $error("low battery action without alert raised");

   // nothing raised means nothing shown
   a_none_shown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_raised_ff == '0) |-> (rsp_shown_ff == SHOWN_NONE))
      else $error("alert shown with empty raised mask");

   // a full input register behind a stalled output blocks new transactions
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("transaction accepted while pipeline stalled");

endmodule

`default_nettype wire

// ----- rtl/asp_slot.sv -----
`timescale 1ns / 1ps
`default_nettype none

module asp_slot
   import asp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire slot_ctrl_type       ctrl,
   input  wire logic [TIME_W-1:0]   now_ms,
   input  wire logic [TIME_W-1:0]   timeout,
   output slot_status_type          status
);

   logic              raised_ff, raised_in;
   logic              raise_handled_ff, raise_handled_in;
   logic              lower_handled_ff, lower_handled_in;
   logic [TIME_W-1:0] raise_time_ff, raise_time_in;
   logic              flag_pre;
   logic              first_raise;
   logic              timeout_hit;

   always_comb begin
      raised_in        = raised_ff;
      raise_handled_in = raise_handled_ff;
      lower_handled_in = lower_handled_ff;
      raise_time_in    = raise_time_ff;
      first_raise      = 1'b0;
      timeout_hit      = 1'b0;
      // external clear first, then external raise
      flag_pre = (raised_ff & ~ctrl.ext_clear) | ctrl.ext_raise;
      if (flag_pre) begin
         if (ctrl.down) begin
            raised_in = 1'b0;
         end else begin
            raised_in = 1'b1;
            if (!raise_handled_ff) begin
               raise_time_in    = now_ms;
               raise_handled_in = 1'b1;
               lower_handled_in = 1'b0;
               first_raise      = 1'b1;
            end else begin
               // wrapping elapsed time; zero on the first handled tick
               timeout_hit = (now_ms - raise_time_ff) > timeout;
            end
         end
      end else begin
         if (ctrl.up) begin
            raised_in = 1'b1;
         end else begin
            raised_in = 1'b0;
            if (!lower_handled_ff) begin
               raise_time_in    = '0;
               lower_handled_in = 1'b1;
               raise_handled_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raised_ff        <= 1'b0;
         raise_handled_ff <= 1'b0;
         lower_handled_ff <= 1'b0;
         raise_time_ff    <= '0;
      end else if (ctrl.advance) begin
         raised_ff        <= raised_in;
         raise_handled_ff <= raise_handled_in;
         lower_handled_ff <= lower_handled_in;
         raise_time_ff    <= raise_time_in;
      end
   end

   assign status.raised      = raised_in;
   assign status.first_raise = first_raise;
   assign status.timeout_hit = timeout_hit;

endmodule

`default_nettype wire

// ----- rtl/asp_prio.sv -----
`timescale 1ns / 1ps
`default_nettype none

module asp_prio
   import asp_pkg::*;
(
   input  wire alert_mask_type     raised_mask,
   input  wire logic               ignore_alerts,
   output logic [SHOWN_W-1:0]      shown_alert
);

   always_comb begin
      shown_alert = SHOWN_NONE;
      if (!ignore_alerts) begin
         // walk from lowest priority up so the lowest raised position wins
         for (int i = NUM_ALERTS - 1; i >= 0; i--) begin
            if (raised_mask[i]) begin
               shown_alert = SHOWN_W'(i);
            end
         end
      end
   end

endmodule

`default_nettype wire

// ----- test/alert_supervisor_priority_top_tb.sv -----
`timescale 1ns / 1ps

module alert_supervisor_priority_top_tb;
   import asp_pkg::*;

   typedef struct {
      logic [TIME_W-1:0]        now_ms;
      logic [LEVEL_W-1:0]       battery_level;
      logic signed [TEMP_W-1:0] cpu_temp;
      logic                     charging;
      alert_mask_type           raise_mask;
      alert_mask_type           clear_mask;
      logic                     ignore_alerts;
   } supervisor_tick_type;

   typedef struct {
      alert_mask_type     raised_mask;
      logic [SHOWN_W-1:0] shown_alert;
      logic               shutdown_request;
      logic               low_battery_action;
      logic               overheat_action;
   } supervisor_status_type;

   // index 7 has no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   asp_req_if req_if ();
   asp_rsp_if rsp_if ();

   alert_supervisor_priority_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // thresholds and delays as the supervisor should currently hold them
   logic [LEVEL_W-1:0]       batt_low_lvl;
   logic [LEVEL_W-1:0]       batt_crit_lvl;
   logic signed [TEMP_W-1:0] temp_high_lvl;
   logic signed [TEMP_W-1:0] temp_rel_lvl;
   logic signed [TEMP_W-1:0] temp_crit_lvl;
   logic [TIME_W-1:0]        batt_delay;
   logic [TIME_W-1:0]        temp_delay;

   // alert bookkeeping
   alert_mask_type    alert_flags;
   alert_mask_type    raise_done;
   alert_mask_type    lower_done;
   logic [TIME_W-1:0] raise_stamp [NUM_ALERTS];
   logic              shutdown_latch;

   supervisor_tick_type   tick_q [$];
   supervisor_status_type expected_status_q [$];
   supervisor_tick_type   cur_tick;
   logic                  req_taken;
   int                    ticks_queued;
   int                    ticks_accepted;
   int                    mismatch_count;
   int                    snd_idle_pct;
   int                    rcv_idle_pct;
   int                    rcv_hold_req;
   int                    rcv_hold_left;
   logic [TIME_W-1:0]     last_now;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic supervisor_status_type supervise_tick(input supervisor_tick_type t);
      supervisor_status_type r;
      logic                  up;
      logic                  down;
      logic [TIME_W-1:0]     limit;
      logic [TIME_W-1:0]     elapsed;
      r.low_battery_action = 1'b0;
      r.overheat_action    = 1'b0;
      alert_flags = (alert_flags & ~t.clear_mask) | t.raise_mask;
      for (int i = 0; i < NUM_ALERTS; i++) begin
         up    = 1'b0;
         down  = 1'b0;
         limit = NEVER_TIMEOUT;
         case (i)
            POS_TEMP_CRIT: begin
               up    = t.cpu_temp >= temp_crit_lvl;
               limit = temp_delay;
            end
            POS_TEMP_HIGH: begin
               up   = t.cpu_temp >= temp_high_lvl;
               down = t.cpu_temp <= temp_rel_lvl;
            end
            POS_BATT_CRIT: begin
               up    = !t.charging && (t.battery_level < batt_crit_lvl);
               down  = t.charging;
               limit = batt_delay;
            end
            POS_BATT_LOW: begin
               up   = !t.charging && (t.battery_level < batt_low_lvl);
               down = t.charging;
            end
            default: ;
         endcase
         if (alert_flags[i]) begin
            if (down) begin
               alert_flags[i] = 1'b0;
            end else begin
               if (!raise_done[i]) begin
                  raise_stamp[i] = t.now_ms;
                  raise_done[i]  = 1'b1;
                  lower_done[i]  = 1'b0;
                  if (i == POS_BATT_LOW) r.low_battery_action = 1'b1;
                  if (i == POS_TEMP_HIGH) r.overheat_action = 1'b1;
               end
               elapsed = t.now_ms - raise_stamp[i];
               if (elapsed > limit) shutdown_latch = 1'b1;
            end
         end else if (up) begin
            alert_flags[i] = 1'b1;
         end else if (!lower_done[i]) begin
            raise_stamp[i] = '0;
            lower_done[i]  = 1'b1;
            raise_done[i]  = 1'b0;
         end
      end
      r.shown_alert = SHOWN_NONE;
      if (!t.ignore_alerts) begin
         for (int i = NUM_ALERTS - 1; i >= 0; i--) begin
            if (alert_flags[i]) r.shown_alert = SHOWN_W'(i);
         end
      end
      r.raised_mask      = alert_flags;
      r.shutdown_request = shutdown_latch;
      return r;
   endfunction

   function automatic supervisor_tick_type mk_tick(input logic [TIME_W-1:0] now,
                                                   input int level, input int temp,
                                                   input logic chg,
                                                   input alert_mask_type rmask,
                                                   input alert_mask_type cmask,
                                                   input logic ign);
      supervisor_tick_type t;
      t.now_ms        = now;
      t.battery_level = LEVEL_W'(level);
      t.cpu_temp      = TEMP_W'(temp);
      t.charging      = chg;
      t.raise_mask    = rmask;
      t.clear_mask    = cmask;
      t.ignore_alerts = ign;
      return t;
   endfunction

   // readings hover around the thresholds so alerts keep rising and clearing
   function automatic supervisor_tick_type random_tick();
      int tv;
      int lv;
      if ($urandom_range(9) == 0) last_now = $urandom;
      else last_now = last_now + $urandom_range(40);
      case ($urandom_range(3))
         0: tv = int'($urandom_range(4095)) - 2048;
         1: tv = int'(temp_high_lvl) + int'($urandom_range(16)) - 8;
         2: tv = int'(temp_rel_lvl) + int'($urandom_range(16)) - 8;
         default: tv = int'(temp_crit_lvl) + int'($urandom_range(16)) - 8;
      endcase
      if (tv > 2047) tv = 2047;
      if (tv < -2048) tv = -2048;
      case ($urandom_range(2))
         0: lv = int'($urandom_range(10000));
         1: lv = int'(batt_low_lvl) + int'($urandom_range(10)) - 5;
         default: lv = int'(batt_crit_lvl) + int'($urandom_range(10)) - 5;
      endcase
      if (lv > 10000) lv = 10000;
      if (lv < 0) lv = 0;
      return mk_tick(last_now, lv, tv, $urandom_range(4) == 0,
                     ($urandom_range(6) == 0) ? alert_mask_type'($urandom & $urandom) : '0,
                     ($urandom_range(6) == 0) ? alert_mask_type'($urandom & $urandom) : '0,
                     $urandom_range(11) == 0);
   endfunction

   task automatic queue_tick(input supervisor_tick_type t);
      tick_q.push_back(t);
      ticks_queued++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_BATT_LOW:   batt_low_lvl  = value[LEVEL_W-1:0];
         CSR_BATT_CRIT:  batt_crit_lvl = value[LEVEL_W-1:0];
         CSR_TEMP_HIGH:  temp_high_lvl = value[TEMP_W-1:0];
         CSR_TEMP_REL:   temp_rel_lvl  = value[TEMP_W-1:0];
         CSR_TEMP_CRIT:  temp_crit_lvl = value[TEMP_W-1:0];
         CSR_BATT_DELAY: batt_delay    = value;
         CSR_TEMP_DELAY: temp_delay    = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all_regs(input int low, input int crit, input int high,
                                 input int rel, input int tcrit,
                                 input logic [TIME_W-1:0] bdelay,
                                 input logic [TIME_W-1:0] tdelay);
      write_reg(CSR_BATT_LOW, CSR_DATA_W'(low));
      write_reg(CSR_BATT_CRIT, CSR_DATA_W'(crit));
      write_reg(CSR_TEMP_HIGH, CSR_DATA_W'(high));
      write_reg(CSR_TEMP_REL, CSR_DATA_W'(rel));
      write_reg(CSR_TEMP_CRIT, CSR_DATA_W'(tcrit));
      write_reg(CSR_BATT_DELAY, bdelay);
      write_reg(CSR_TEMP_DELAY, tdelay);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (ticks_accepted != ticks_queued || expected_status_q.size() != 0);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         req_taken = 1'b0;
         if (tick_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
            cur_tick = tick_q.pop_front();
            req_if.now_ms        <= cur_tick.now_ms;
            req_if.battery_level <= cur_tick.battery_level;
            req_if.cpu_temp      <= cur_tick.cpu_temp;
            req_if.charging      <= cur_tick.charging;
            req_if.raise_mask    <= cur_tick.raise_mask;
            req_if.clear_mask    <= cur_tick.clear_mask;
            req_if.ignore_alerts <= cur_tick.ignore_alerts;
            req_if.valid         <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver, with a long hold-off when one is requested
   always @(negedge clock) begin
      if (rcv_hold_req > 0) begin
         rcv_hold_left = rcv_hold_req;
         rcv_hold_req  = 0;
      end
      if (rcv_hold_left > 0) begin
         rcv_hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      supervisor_status_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_status_q.size() == 0) begin
               $error("unexpected transaction: raised_mask %h shown_alert %0d",
                      rsp_if.raised_mask, rsp_if.shown_alert);
               mismatch_count++;
            end else begin
               want = expected_status_q.pop_front();
               if (rsp_if.raised_mask !== want.raised_mask) begin
                  $error("raised_mask: expected %h, got %h", want.raised_mask,
                         rsp_if.raised_mask);
                  mismatch_count++;
               end
               if (rsp_if.shown_alert !== want.shown_alert) begin
                  $error("shown_alert: expected %0d, got %0d", want.shown_alert,
                         rsp_if.shown_alert);
                  mismatch_count++;
               end
               if (rsp_if.shutdown_request !== want.shutdown_request) begin
                  $error("shutdown_request: expected %b, got %b", want.shutdown_request,
                         rsp_if.shutdown_request);
                  mismatch_count++;
               end
               if (rsp_if.low_battery_action !== want.low_battery_action) begin
                  $error("low_battery_action: expected %b, got %b",
                         want.low_battery_action, rsp_if.low_battery_action);
                  mismatch_count++;
               end
               if (rsp_if.overheat_action !== want.overheat_action) begin
                  $error("overheat_action: expected %b, got %b", want.overheat_action,
                         rsp_if.overheat_action);
                  mismatch_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            expected_status_q.push_back(supervise_tick(cur_tick));
            ticks_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [TIME_W-1:0] t0;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.now_ms        = '0;
      req_if.battery_level = '0;
      req_if.cpu_temp      = '0;
      req_if.charging      = 1'b0;
      req_if.raise_mask    = '0;
      req_if.clear_mask    = '0;
      req_if.ignore_alerts = 1'b0;
      rsp_if.ready         = 1'b0;
      req_taken            = 1'b0;
      ticks_queued         = 0;
      ticks_accepted       = 0;
      mismatch_count       = 0;
      snd_idle_pct         = 23;
      rcv_idle_pct         = 70;
      rcv_hold_req         = 0;
      rcv_hold_left        = 0;
      last_now             = '0;
      batt_low_lvl         = BATT_LOW_RESET;
      batt_crit_lvl        = BATT_CRIT_RESET;
      temp_high_lvl        = TEMP_HIGH_RESET;
      temp_rel_lvl         = TEMP_REL_RESET;
      temp_crit_lvl        = TEMP_CRIT_RESET;
      batt_delay           = BATT_DELAY_RESET;
      temp_delay           = TEMP_DELAY_RESET;
      alert_flags          = '0;
      raise_done           = '0;
      lower_done           = '0;
      shutdown_latch       = 1'b0;
      for (int i = 0; i < NUM_ALERTS; i++) raise_stamp[i] = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default thresholds, timeouts out of reach
      write_all_regs(3000, 1000, 960, 720, 1120, NEVER_TIMEOUT, NEVER_TIMEOUT);
      write_reg(CSR_SPARE_INDEX, $urandom);
      queue_tick(mk_tick(32'd0, 10000, 0, 1'b0, '0, '0, 1'b0));
      queue_tick(mk_tick(32'd10, 10000, 0, 1'b0, '1, '0, 1'b0));
      queue_tick(mk_tick(32'd20, 10000, 0, 1'b0, '0, '1, 1'b0));
      // raise and clear of the same alert: raise wins
      queue_tick(mk_tick(32'd30, 10000, 0, 1'b0, '1, '1, 1'b0));
      queue_tick(mk_tick(32'd40, 10000, 0, 1'b1, '0, '1, 1'b0));
      queue_tick(mk_tick(32'd50, 10000, 2047, 1'b0, '0, '0, 1'b1));
      queue_tick(mk_tick(32'd60, 10000, 2047, 1'b0, '0, '0, 1'b0));
      queue_tick(mk_tick(32'd70, 10000, -2048, 1'b0, '0, '0, 1'b0));
      // overheat raised again before its lowered tick: no fresh action
      queue_tick(mk_tick(32'd80, 10000, 800, 1'b0, 10'h004, '0, 1'b0));
      queue_tick(mk_tick(32'd90, 0, 800, 1'b0, '0, '0, 1'b0));
      queue_tick(mk_tick(32'd100, 0, 800, 1'b0, '0, '0, 1'b0));
      queue_tick(mk_tick(32'd110, 0, 800, 1'b1, '0, '0, 1'b0));
      queue_tick(mk_tick(32'd120, 10000, 800, 1'b0, 10'h020, '0, 1'b0));
      queue_tick(mk_tick(32'd130, 10000, 800, 1'b0, '0, 10'h020, 1'b0));
      queue_tick(mk_tick(32'd140, 2999, 800, 1'b0, '0, '0, 1'b0));
      queue_tick(mk_tick(32'd150, 3000, 800, 1'b0, '0, '0, 1'b0));
      queue_tick(mk_tick(32'd160, 1000, 960, 1'b0, '0, '0, 1'b0));
      queue_tick(mk_tick(32'd170, 999, 720, 1'b0, '0, '0, 1'b0));
      queue_tick(mk_tick(32'd180, 10000, 1119, 1'b1, '0, 10'h002, 1'b0));
      queue_tick(mk_tick(32'd190, 10000, 1120, 1'b1, '0, '0, 1'b0));
      queue_tick(mk_tick(32'hFFFF_FFFF, 10000, 0, 1'b1, '0, '1, 1'b0));
      queue_tick(mk_tick(32'hFFFF_FFFF, 10000, 0, 1'b1, 10'h200, '0, 1'b0));
      queue_tick(mk_tick(32'd5, 10000, 0, 1'b1, 10'h1FF, '0, 1'b1));
      last_now = 32'd5;
      wait_drained();

      // moderate thresholds
      write_all_regs(5000, 2500, 400, 100, 1000, NEVER_TIMEOUT, NEVER_TIMEOUT);
      repeat (340) queue_tick(random_tick());
      wait_drained();

      // extreme thresholds, sender now the slow side
      write_all_regs(16383, 0, -2048, 2047, 2047, NEVER_TIMEOUT, NEVER_TIMEOUT);
      snd_idle_pct = 70;
      rcv_idle_pct = 23;
      repeat (340) queue_tick(random_tick());
      rcv_hold_req = 400;
      wait_drained();

      // shutdown timing, straddling the wrap of the millisecond counter
      write_all_regs(3000, 1000, 960, 720, 1500, 32'd100, 32'd0);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      t0 = 32'hFFFF_FFC2;
      queue_tick(mk_tick(t0 - 32'd2, 10000, 0, 1'b1, '0, '1, 1'b0));
      queue_tick(mk_tick(t0 - 32'd1, 500, 0, 1'b0, '0, '0, 1'b0));
      queue_tick(mk_tick(t0, 500, 0, 1'b0, '0, '0, 1'b0));
      queue_tick(mk_tick(t0 + 32'd100, 500, 0, 1'b0, '0, '0, 1'b0));
      queue_tick(mk_tick(t0 + 32'd101, 500, 0, 1'b0, '0, '0, 1'b0));
      last_now = t0 + 32'd101;
      repeat (340) queue_tick(random_tick());
      wait_drained();

      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
